// File: design/spi_clock_divisor_calc_unit_macros.svh
// ----------------------------------------------------------------------------
// SPI clock divisor calculator - assertion macros
// Concurrent check wrappers shared by the RTL files; compiled out when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef SPI_CLOCK_DIVISOR_CALC_UNIT_MACROS_SVH
`define SPI_CLOCK_DIVISOR_CALC_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define CDC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Expression must never be true outside reset.
`define CDC_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define CDC_ASSERT(lbl, clk, rstn, prop, msg)
`define CDC_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// File: design/spi_cdc_pkg.sv
// ----------------------------------------------------------------------------
// SPI clock divisor calculator - package
// Shared widths, constants, codes and controller/datapath command types.
// ----------------------------------------------------------------------------
`default_nettype none

package spi_cdc_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned CntW  = $clog2(DataW + 1);

    localparam logic [DataW-1:0] SysClkRst = 32'd120000000;
    localparam logic [DataW-1:0] PreDivisor = 32'd257;
    localparam logic [DataW-1:0] SatQuo = 32'd254;
    localparam logic [7:0]       PreMax = 8'd254;
    localparam logic [8:0]       ScrSatQuo = 9'd256;

    // m/257 reaches the saturation quotient from this m upwards
    localparam logic [DataW-1:0] PreSatM = SatQuo * PreDivisor;
    // below PreSatM, m/257 equals (m * PreRecip) >> PreRecipShift
    localparam logic [16:0]      PreRecip = 17'd65281;
    localparam int unsigned      PreRecipShift = 24;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_SAT  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        DSEL_M,
        DSEL_P,
        DSEL_SCR,
        DSEL_ACT
    } div_sel_t;

    typedef enum logic [1:0] {
        RES_HIT,
        RES_ZERO,
        RES_CALC
    } res_kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOKUP,
        S_M_WAIT,
        S_P_CALC,
        S_S_START,
        S_S_WAIT,
        S_A_START,
        S_A_WAIT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic      load;
        logic      lookup;
        logic      div_start;
        div_sel_t  div_sel;
        logic      take;
        logic      finish;
        res_kind_t kind;
    } cdc_cmd_t;

    typedef struct packed {
        logic hit;
        logic f_zero;
        logic sat;
        logic div_done;
        logic out_free;
    } cdc_sts_t;

endpackage

`default_nettype wire

// File: design/spi_cdc_if.sv
// ----------------------------------------------------------------------------
// SPI clock divisor calculator - channel interfaces
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
`default_nettype none

interface spi_cdc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  port;
    logic [31:0] requested_hz;

    modport source (output valid, output port, output requested_hz, input ready);
    modport sink   (input valid, input port, input requested_hz, output ready);
endinterface

interface spi_cdc_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  prescaler;
    logic [7:0]  rate_factor;
    logic [31:0] actual_hz;
    logic        recomputed;
    logic [1:0]  status;

    modport source (output valid, output prescaler, output rate_factor, output actual_hz,
                     output recomputed, output status, input ready);
    modport sink   (input valid, input prescaler, input rate_factor, input actual_hz,
                     input recomputed, input status, output ready);
endinterface

`default_nettype wire

// File: design/spi_clock_divisor_calc_unit.sv
// ----------------------------------------------------------------------------
// SPI clock divisor calculator - top level
// Per-port serial clock prescaler and rate factor calculation with a cached
// last setting per port.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake       Payload
//  --------  ---  --------------  -------------------------------------------
//  in_ch     in   valid/ready     port, requested_hz
//  out_ch    out  valid/ready     prescaler, rate_factor, actual_hz,
//                                 recomputed, status
//  cfg       in   cfg_wr_en only  cfg_wr_data -> system clock in Hz
//
//  One item at a time. A cache hit or a zero request goes from the lookup
//  step straight to the finish step. A computed item passes serially
//  three times through the shared 32-bit divider at one quotient bit per
//  cycle (two passes when the prescaler saturates); the prescaler itself
//  comes from a reciprocal multiply.
//  Reset clears the per-port cache and loads the system clock register with
//  120 MHz. A result waits in the output register while the next request
//  transfers in; the controller only holds in its finish step while that
//  register is still occupied and not being drained. Write the system clock
//  register only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_clock_divisor_calc_unit
    import spi_cdc_pkg::*;
#(
    parameter int NUM_PORTS = 4
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [DataW-1:0] cfg_wr_data,
    spi_cdc_in_if.sink            in_ch,
    spi_cdc_out_if.source         out_ch
);

    // command and status between sequencer and datapath
    cdc_cmd_t cmd;
    cdc_sts_t sts;

    // controller: drives in_ch.ready, issues loads, divider starts and finish
    spi_cdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: cache, shared divider and the output register
    spi_cdc_dp #(
        .NUM_PORTS (NUM_PORTS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_port         (in_ch.port),
        .in_requested_hz (in_ch.requested_hz),
        .cmd             (cmd),
        .sts             (sts),
        .out_ready       (out_ch.ready),
        .out_valid       (out_ch.valid),
        .out_prescaler   (out_ch.prescaler),
        .out_rate_factor (out_ch.rate_factor),
        .out_actual_hz   (out_ch.actual_hz),
        .out_recomputed  (out_ch.recomputed),
        .out_status      (out_ch.status)
    );

endmodule

`default_nettype wire

// File: design/spi_cdc_div.sv
// ----------------------------------------------------------------------------
// SPI clock divisor calculator - shared divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "spi_clock_divisor_calc_unit_macros.svh"

module spi_cdc_div
    import spi_cdc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DataW-1:0] dividend,
    input  wire logic [DataW-1:0] divisor,
    output logic                  done,
    output logic [DataW-1:0]      quotient
);

    logic             busy_reg;
    logic [CntW-1:0]  cnt_reg;
    logic [DataW:0]   rem_reg;
    logic [DataW-1:0] quo_reg;
    logic [DataW-1:0] den_reg;

    logic [DataW:0]   shifted;
    logic             ge;
    logic [DataW:0]   rem_next;
    logic [DataW-1:0] quo_next;

    always_comb
    begin
        shifted  = {rem_reg[DataW-1:0], quo_reg[DataW-1]};
        ge       = (shifted >= {1'b0, den_reg});
        rem_next = ge ? (shifted - {1'b0, den_reg}) : shifted;
        quo_next = {quo_reg[DataW-2:0], ge};
    end

    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CntW'(DataW);
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            else
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    // a new division must not cut into one still in progress
    `CDC_ASSERT(a_div_no_restart, clk, rst_n, start |-> !busy_reg, "divider restarted while busy")

endmodule

`default_nettype wire

// File: design/spi_cdc_dp.sv
// ----------------------------------------------------------------------------
// SPI clock divisor calculator - datapath
// Per-port cache, clamp, divider operand selection, prescaler calculation and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "spi_clock_divisor_calc_unit_macros.svh"

module spi_cdc_dp
    import spi_cdc_pkg::*;
#(
    parameter int NUM_PORTS = 4
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [DataW-1:0] cfg_wr_data,
    input  wire logic [1:0]       in_port,
    input  wire logic [DataW-1:0] in_requested_hz,
    input  wire cdc_cmd_t         cmd,
    output cdc_sts_t              sts,
    input  wire logic             out_ready,
    output logic                  out_valid,
    output logic [7:0]            out_prescaler,
    output logic [7:0]            out_rate_factor,
    output logic [DataW-1:0]      out_actual_hz,
    output logic                  out_recomputed,
    output logic [1:0]            out_status
);

    localparam int unsigned PortIdxW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int unsigned PortVals = 4;

    logic [DataW-1:0]    sys_clk_reg;
    logic [DataW-1:0]    last_req_reg [NUM_PORTS];
    logic [DataW-1:0]    last_act_reg [NUM_PORTS];

    logic [PortIdxW-1:0] idx_reg;
    logic [DataW-1:0]    req_reg;
    logic [DataW-1:0]    f_reg;
    logic [DataW-1:0]    m_reg;
    logic [7:0]          p_reg;
    logic [8:0]          scrq_reg;
    logic [DataW-1:0]    act_reg;
    logic                sat_reg;
    logic                out_valid_reg;

    logic [7:0]          pre_out_reg;
    logic [7:0]          fac_out_reg;
    logic [DataW-1:0]    act_out_reg;
    logic                rec_out_reg;
    status_t             st_out_reg;

    logic [PortIdxW-1:0] port_fold [PortVals];
    logic [PortIdxW-1:0] port_idx;
    logic [DataW-1:0]    half;
    logic [DataW-1:0]    clamp;
    logic [16:0]         prod;
    logic [8:0]          scr_m1;
    logic [DataW-1:0]    pq_prod;
    logic [7:0]          pq;
    logic [7:0]          p_calc;
    logic                p_sat;
    logic [DataW-1:0]    div_dividend;
    logic [DataW-1:0]    div_divisor;
    logic                div_done;
    logic [DataW-1:0]    div_quo;

    // fold out-of-range port numbers back onto the implemented ports
    for (genvar g = 0; g < PortVals; g++)
    begin : g_port_fold
        assign port_fold[g] = PortIdxW'(g % NUM_PORTS);
    end
    assign port_idx = port_fold[in_port];

    assign half  = sys_clk_reg >> 1;
    assign clamp = (req_reg > half) ? half : req_reg;
    assign prod  = {9'd0, p_reg} * {8'd0, scrq_reg};
    assign scr_m1 = scrq_reg - 9'd1;

    // m/257 by reciprocal multiply; only needed below the saturation point,
    // where m fits in 16 bits
    assign pq_prod = {16'd0, m_reg[15:0]} * {15'd0, PreRecip};
    assign pq      = pq_prod[PreRecipShift +: 8];

    // smallest even prescaler above m/257
    assign p_sat  = (m_reg >= PreSatM);
    assign p_calc = pq[0] ? (pq + 8'd1) : (pq + 8'd2);

    always_comb
    begin
        case (cmd.div_sel)
            DSEL_M:
            begin
                div_dividend = sys_clk_reg;
                div_divisor  = clamp;
            end
            DSEL_SCR:
            begin
                div_dividend = m_reg;
                div_divisor  = {24'd0, p_reg};
            end
            DSEL_ACT:
            begin
                div_dividend = sys_clk_reg;
                div_divisor  = {15'd0, prod};
            end
            default:
            begin
                div_dividend = sys_clk_reg;
                div_divisor  = clamp;
            end
        endcase
    end

    spi_cdc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        sts.hit      = (req_reg == last_req_reg[idx_reg]);
        sts.f_zero   = (clamp == '0);
        sts.sat      = sat_reg;
        sts.div_done = div_done;
        sts.out_free = !out_valid_reg || out_ready;
    end

    // configuration, cache and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sys_clk_reg   <= SysClkRst;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                last_req_reg[i] <= '0;
                last_act_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                sys_clk_reg <= cfg_wr_data;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                if (cmd.kind == RES_CALC)
                begin
                    last_req_reg[idx_reg] <= f_reg;
                    last_act_reg[idx_reg] <= act_reg;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg <= port_idx;
            req_reg <= in_requested_hz;
        end
        if (cmd.lookup)
        begin
            f_reg <= clamp;
        end
        if (cmd.take)
        begin
            case (cmd.div_sel)
                DSEL_M:
                begin
                    m_reg <= div_quo;
                end
                DSEL_P:
                begin
                    if (p_sat)
                    begin
                        p_reg    <= PreMax;
                        scrq_reg <= ScrSatQuo;
                        sat_reg  <= 1'b1;
                    end
                    else
                    begin
                        p_reg   <= p_calc;
                        sat_reg <= 1'b0;
                    end
                end
                DSEL_SCR:
                begin
                    scrq_reg <= div_quo[8:0];
                end
                DSEL_ACT:
                begin
                    act_reg <= div_quo;
                end
                default:
                begin
                    m_reg <= div_quo;
                end
            endcase
        end
        if (cmd.finish)
        begin
            case (cmd.kind)
                RES_HIT:
                begin
                    pre_out_reg <= '0;
                    fac_out_reg <= '0;
                    act_out_reg <= last_act_reg[idx_reg];
                    rec_out_reg <= 1'b0;
                    st_out_reg  <= ST_OK;
                end
                RES_ZERO:
                begin
                    pre_out_reg <= '0;
                    fac_out_reg <= '0;
                    act_out_reg <= '0;
                    rec_out_reg <= 1'b0;
                    st_out_reg  <= ST_ZERO;
                end
                RES_CALC:
                begin
                    pre_out_reg <= p_reg;
                    fac_out_reg <= scr_m1[7:0];
                    act_out_reg <= act_reg;
                    rec_out_reg <= 1'b1;
                    st_out_reg  <= sat_reg ? ST_SAT : ST_OK;
                end
                default:
                begin
                    pre_out_reg <= '0;
                    fac_out_reg <= '0;
                    act_out_reg <= '0;
                    rec_out_reg <= 1'b0;
                    st_out_reg  <= ST_ZERO;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_prescaler   = pre_out_reg;
    assign out_rate_factor = fac_out_reg;
    assign out_actual_hz   = act_out_reg;
    assign out_recomputed  = rec_out_reg;
    assign out_status      = st_out_reg;

    `CDC_ASSERT_NEVER(a_dp_div_zero, clk, rst_n, cmd.div_start && (div_divisor == '0), "divider started with zero divisor")
    `CDC_ASSERT(a_dp_out_source, clk, rst_n, $rose(out_valid_reg) |-> $past(cmd.finish), "result raised without finish")

endmodule

`default_nettype wire

// File: design/spi_cdc_ctrl.sv
// ----------------------------------------------------------------------------
// SPI clock divisor calculator - controller
// Sequences lookup, the divisions, the prescaler step and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
`include "spi_clock_divisor_calc_unit_macros.svh"

module spi_cdc_ctrl
    import spi_cdc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire cdc_sts_t sts,
    output cdc_cmd_t      cmd
);

    state_t    state_reg;
    state_t    state_next;
    res_kind_t kind_reg;
    res_kind_t kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= RES_HIT;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.kind   = kind_reg;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                if (sts.hit)
                begin
                    kind_next  = RES_HIT;
                    state_next = S_FINISH;
                end
                else if (sts.f_zero)
                begin
                    kind_next  = RES_ZERO;
                    state_next = S_FINISH;
                end
                else
                begin
                    kind_next     = RES_CALC;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DSEL_M;
                    state_next    = S_M_WAIT;
                end
            end
            S_M_WAIT:
            begin
                cmd.div_sel = DSEL_M;
                if (sts.div_done)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_P_CALC;
                end
            end
            S_P_CALC:
            begin
                // prescaler comes straight from m, no division needed
                cmd.take    = 1'b1;
                cmd.div_sel = DSEL_P;
                state_next  = S_S_START;
            end
            S_S_START:
            begin
                // saturated prescaler fixes the factor, skip its division
                if (sts.sat)
                begin
                    state_next = S_A_START;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DSEL_SCR;
                    state_next    = S_S_WAIT;
                end
            end
            S_S_WAIT:
            begin
                cmd.div_sel = DSEL_SCR;
                if (sts.div_done)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_A_START;
                end
            end
            S_A_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_ACT;
                state_next    = S_A_WAIT;
            end
            S_A_WAIT:
            begin
                cmd.div_sel = DSEL_ACT;
                if (sts.div_done)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `CDC_ASSERT(a_ctrl_load_lookup, clk, rst_n, cmd.load |=> cmd.lookup, "lookup did not follow load")
    `CDC_ASSERT(a_ctrl_div_latency, clk, rst_n, cmd.div_start |=> !sts.div_done, "divider finished too early")

endmodule

`default_nettype wire
